FILE: rtl/core/fbg_pkg.sv
// Package: request types, parse phases and constants of the FBG packet record parser.
`timescale 1ns / 1ps
`default_nettype none
package fbg_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WL_W     = 21;
    localparam int unsigned WAVE_W   = 16;
    localparam int unsigned PHYS_W   = 32;
    localparam int unsigned CNT_W    = 8;
    localparam int unsigned BIDX_W   = 3;

    localparam logic [BYTE_W-1:0] HDR_F = 8'h46;
    localparam logic [BYTE_W-1:0] HDR_B = 8'h42;
    localparam logic [BYTE_W-1:0] HDR_G = 8'h47;
    localparam logic [BYTE_W-1:0] HDR_V = 8'h56;
    localparam logic [BYTE_W-1:0] HDR_W = 8'h57;

    localparam logic [WL_W-1:0] WL_OFFSET_RESET = 21'd1520000;
    localparam logic [WL_W-1:0] WL_MAX          = {WL_W{1'b1}};

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_CHCOUNT = 3'd1,
        PH_SNCOUNT = 3'd2,
        PH_WAVE    = 3'd3,
        PH_PHYS    = 3'd4,
        PH_IGNORE  = 3'd5
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              last_byte;
    } t_in_req;

    typedef struct packed {
        logic [CNT_W-1:0]  channel_number;
        logic [CNT_W-1:0]  sensor_number;
        logic              has_physical;
        logic [WL_W-1:0]   wavelength_pm;
        logic [PHYS_W-1:0] physical_bits;
    } t_out_req;

endpackage
`default_nettype wire

FILE: rtl/core/fbg_in_stage.sv
// Input register stage: holds one byte request until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none
module fbg_in_stage
    import fbg_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_in_req i_req,
    output logic         o_stall,
    input  wire logic    i_take,
    output logic         o_valid,
    output t_in_req      o_req
);

    logic    r_valid;
    logic    n_valid;
    t_in_req r_req;
    logic    accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule
`default_nettype wire

FILE: rtl/core/fbg_parser.sv
// Parser: header check, counters and record assembly, one byte per cycle while the result register is not busy.
`timescale 1ns / 1ps
`default_nettype none
module fbg_parser
    import fbg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire t_in_req          i_req,
    input  wire logic             i_out_busy,
    input  wire logic [WL_W-1:0]  i_wl_offset,
    output logic                  o_take,
    output logic                  o_res_valid,
    output t_out_req              o_res
);

    t_phase              r_phase, n_phase;
    logic [BIDX_W-1:0]   r_bidx, n_bidx;
    logic                r_present, n_present;
    logic [CNT_W-1:0]    r_ch_total, n_ch_total;
    logic [CNT_W-1:0]    r_ch_idx, n_ch_idx;
    logic [CNT_W-1:0]    r_sn_total, n_sn_total;
    logic [CNT_W-1:0]    r_sn_idx, n_sn_idx;
    logic [WAVE_W-1:0]   r_wave, n_wave;
    logic [PHYS_W-1:0]   r_phys, n_phys;

    logic [BYTE_W-1:0]   b;
    logic [CNT_W-1:0]    ch_next;
    logic [CNT_W-1:0]    sn_next;
    logic                finish;
    logic [WAVE_W-1:0]   rec_wave;
    logic [PHYS_W-1:0]   rec_phys;
    logic [WL_W:0]       wl_sum;

    assign o_take  = i_valid && !i_out_busy;
    assign b       = i_req.byte_value;
    assign ch_next = r_ch_idx + 1'b1;
    assign sn_next = r_sn_idx + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_bidx     = r_bidx;
        n_present  = r_present;
        n_ch_total = r_ch_total;
        n_ch_idx   = r_ch_idx;
        n_sn_total = r_sn_total;
        n_sn_idx   = r_sn_idx;
        n_wave     = r_wave;
        n_phys     = r_phys;
        finish     = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                priority if (r_bidx == 3'd0 && b == HDR_F) begin
                    n_bidx = 3'd1;
                end else if (r_bidx == 3'd1 && b == HDR_B) begin
                    n_bidx = 3'd2;
                end else if (r_bidx == 3'd2 && b == HDR_G) begin
                    n_bidx = 3'd3;
                end else if (r_bidx == 3'd3 && (b == HDR_V || b == HDR_W)) begin
                    n_present = (b == HDR_V);
                    n_bidx    = 3'd0;
                    n_phase   = PH_CHCOUNT;
                end else begin
                    n_phase = PH_IGNORE;
                end
            end
            PH_CHCOUNT: begin
                n_ch_total = b;
                n_ch_idx   = '0;
                n_phase    = (b == '0) ? PH_IGNORE : PH_SNCOUNT;
            end
            PH_SNCOUNT: begin
                n_sn_total = b;
                n_sn_idx   = '0;
                n_bidx     = 3'd0;
                if (b == '0) begin
                    n_ch_idx = ch_next;
                    n_phase  = (ch_next >= r_ch_total) ? PH_IGNORE : PH_SNCOUNT;
                end else begin
                    n_phase = PH_WAVE;
                end
            end
            PH_WAVE: begin
                if (r_bidx == 3'd0) begin
                    n_wave = {8'd0, b};
                    n_bidx = 3'd1;
                end else begin
                    n_wave = {b, r_wave[7:0]};
                    n_bidx = 3'd0;
                    n_phys = '0;
                    if (r_present) begin
                        n_phase = PH_PHYS;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            PH_PHYS: begin
                unique case (r_bidx[1:0])
                    2'd0: n_phys = {r_phys[31:8], b};
                    2'd1: n_phys = {r_phys[31:16], b, r_phys[7:0]};
                    2'd2: n_phys = {r_phys[31:24], b, r_phys[15:0]};
                    2'd3: n_phys = {b, r_phys[23:0]};
                    default: n_phys = r_phys;
                endcase
                if (r_bidx >= 3'd3) begin
                    finish = 1'b1;
                end else begin
                    n_bidx = r_bidx + 1'b1;
                end
            end
            default: begin
            end
        endcase

        // advance counters past a completed record
        if (finish) begin
            n_sn_idx = sn_next;
            n_bidx   = 3'd0;
            if (sn_next >= r_sn_total) begin
                n_ch_idx = ch_next;
                n_sn_idx = '0;
                n_phase  = (ch_next >= r_ch_total) ? PH_IGNORE : PH_SNCOUNT;
            end else begin
                n_phase = PH_WAVE;
            end
        end

        // hold the record fields before the end of packet clears them
        rec_wave = n_wave;
        rec_phys = n_phys;

        if (i_req.last_byte) begin
            n_phase    = PH_HEADER;
            n_bidx     = '0;
            n_present  = 1'b0;
            n_ch_total = '0;
            n_ch_idx   = '0;
            n_sn_total = '0;
            n_sn_idx   = '0;
            n_wave     = '0;
            n_phys     = '0;
        end
    end

    assign wl_sum = {{(WL_W + 1 - WAVE_W){1'b0}}, rec_wave} + {1'b0, i_wl_offset};

    always_comb begin
        o_res_valid          = o_take && finish;
        o_res.channel_number = ch_next;
        o_res.sensor_number  = sn_next;
        o_res.has_physical   = r_present;
        o_res.wavelength_pm  = wl_sum[WL_W] ? WL_MAX : wl_sum[WL_W-1:0];
        o_res.physical_bits  = r_present ? rec_phys : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_bidx     <= '0;
            r_present  <= 1'b0;
            r_ch_total <= '0;
            r_ch_idx   <= '0;
            r_sn_total <= '0;
            r_sn_idx   <= '0;
            r_wave     <= '0;
            r_phys     <= '0;
        end else if (o_take) begin
            r_phase    <= n_phase;
            r_bidx     <= n_bidx;
            r_present  <= n_present;
            r_ch_total <= n_ch_total;
            r_ch_idx   <= n_ch_idx;
            r_sn_total <= n_sn_total;
            r_sn_idx   <= n_sn_idx;
            r_wave     <= n_wave;
            r_phys     <= n_phys;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/fbg_out_stage.sv
// Result register stage: holds one record request until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module fbg_out_stage
    import fbg_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    input  wire t_out_req i_res,
    input  wire logic     i_stall,
    output logic          o_busy,
    output logic          o_valid,
    output t_out_req      o_req
);

    logic     r_valid;
    logic     n_valid;
    t_out_req r_req;

    assign o_busy = r_valid && i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_req <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule
`default_nettype wire

FILE: rtl/core/fbg_packet_record_parser.sv
// Top level of the FBG packet record parser.
//
// Input channel: i_valid / o_stall with i_req, one datagram byte per request,
// last_byte set on the final byte. Output channel: o_valid / i_stall with
// o_req, one request per completed sensor record (channel, sensor, wavelength
// in pm, raw physical value bits).
// Configuration: i_cfg_we writes i_cfg_data into the wavelength offset.
// Path: a byte is captured in the input register and parsed combinationally
// from there; a record it completes is captured in the result register,
// which drives o_valid and o_req.
// Throughput: one byte per cycle unless a receiver stall holds the result
// register; the parse step between the two registers is combinational.
// Reset: synchronous, active low; the parser returns to the header phase,
// both registers empty, offset back to 1520000 pm.
// Receiver stall: the result register holds; the parser holds its byte and
// o_stall rises once the input register is full.
`timescale 1ns / 1ps
`default_nettype none
module fbg_packet_record_parser
    import fbg_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire t_in_req         i_req,
    output logic                 o_stall,
    output logic                 o_valid,
    output t_out_req             o_req,
    input  wire logic            i_stall,
    input  wire logic            i_cfg_we,
    input  wire logic [WL_W-1:0] i_cfg_data
);

    logic [WL_W-1:0] r_wl_offset;
    logic            in_valid;
    t_in_req         in_req;
    logic            take;
    logic            out_busy;
    logic            res_valid;
    t_out_req        res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl_offset <= WL_OFFSET_RESET;
        end else if (i_cfg_we) begin
            r_wl_offset <= i_cfg_data;
        end
    end

    fbg_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_stall (o_stall),
        .i_take  (take),
        .o_valid (in_valid),
        .o_req   (in_req)
    );

    fbg_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_req       (in_req),
        .i_out_busy  (out_busy),
        .i_wl_offset (r_wl_offset),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    fbg_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_busy  (out_busy),
        .o_valid (o_valid),
        .o_req   (o_req)
    );

endmodule
`default_nettype wire
